[rtl/hlbc_pkg.sv]
package hlbc_pkg;

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int SEL_W = 5;
    localparam int CNT_W = 8;
    localparam int TAG_W = DEV_W + BLK_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_GET,
        OP_RELEASE,
        OP_PIN,
        OP_UNPIN
    } t_op;

    typedef enum logic [1:0] {
        STS_OK,
        STS_NOFREE,
        STS_UNDER,
        STS_OVER
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [DEV_W-1:0]   dev;
        logic [BLK_W-1:0]   blockno;
        logic [SEL_W-1:0]   buffer_select;
    } t_req;

    typedef struct packed {
        logic [SEL_W-1:0]   buffer_index;
        logic               hit;
        logic               need_read;
        t_status            status;
    } t_rsp;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_MOD_START,
        DP_MOD_STEP,
        DP_HEAD_RD,
        DP_HCHK,
        DP_HCMP,
        DP_HIT_UPD,
        DP_L_START,
        DP_L_NB,
        DP_L_CHK,
        DP_L_CMP,
        DP_GOT,
        DP_U_RD,
        DP_U_WR,
        DP_P_RD,
        DP_P_WR1,
        DP_P_WR2,
        DP_SEL_RD,
        DP_CNT_UPD
    } t_dp_op;

    typedef enum logic [1:0] {
        IDX_NODE,
        IDX_SEL,
        IDX_ZERO
    } t_idx_src;

    typedef struct packed {
        t_dp_op     op;
        logic       out_load;
        logic       res_hit;
        logic       res_need;
        t_status    res_status;
        t_idx_src   res_src;
    } t_cmd;

    typedef struct packed {
        t_op    op;
        logic   init_last;
        logic   mod_last;
        logic   cand_head;
        logic   tag_match;
        logic   cnt_zero;
        logic   cnt_one;
        logic   cnt_max;
        logic   cv;
        logic   k_done;
        logic   sel_ok;
    } t_stat;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SEL,
        S_SCHK,
        S_MOD_START,
        S_MOD,
        S_HEAD,
        S_HCHK,
        S_HCMP,
        S_HIT,
        S_LSTART,
        S_LNB,
        S_LCHK,
        S_LCMP,
        S_GOT,
        S_URD,
        S_UWR,
        S_PRD,
        S_PWR1,
        S_PWR2,
        S_DONE
    } t_state;

endpackage

[rtl/hlbc_stream_if.sv]
interface hlbc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/hlbc_ctrl.sv]
module hlbc_ctrl import hlbc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state   r_state, n_state;
    logic     r_ovalid, n_ovalid;
    logic     r_hit, n_hit;
    logic     r_need, n_need;
    t_status  r_st, n_st;
    t_idx_src r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
            r_need   <= 1'b0;
            r_st     <= STS_OK;
            r_src    <= IDX_SEL;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_hit    <= n_hit;
            r_need   <= n_need;
            r_st     <= n_st;
            r_src    <= n_src;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_hit    = r_hit;
        n_need   = r_need;
        n_st     = r_st;
        n_src    = r_src;
        o_in_ready = 1'b0;
        o_cmd.op         = DP_NOP;
        o_cmd.out_load   = 1'b0;
        o_cmd.res_hit    = r_hit;
        o_cmd.res_need   = r_need;
        o_cmd.res_status = r_st;
        o_cmd.res_src    = r_src;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                o_cmd.op = DP_INIT;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_SEL;
                end
            end
            S_SEL: begin
                n_hit  = 1'b0;
                n_need = 1'b0;
                n_st   = STS_OK;
                n_src  = IDX_SEL;
                if (i_stat.op == OP_GET) begin
                    n_state = S_MOD_START;
                end else if (!i_stat.sel_ok) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_SEL_RD;
                    n_state  = S_SCHK;
                end
            end
            S_SCHK: begin
                n_state = S_DONE;
                if (i_stat.op == OP_PIN) begin
                    if (i_stat.cnt_max) begin
                        n_st = STS_OVER;
                    end else begin
                        o_cmd.op = DP_CNT_UPD;
                    end
                end else if (i_stat.cnt_zero) begin
                    n_st = STS_UNDER;
                end else begin
                    o_cmd.op = DP_CNT_UPD;
                    // last reference dropped: move to head of its hash bucket
                    if (i_stat.op == OP_RELEASE && i_stat.cnt_one) begin
                        n_state = S_MOD_START;
                    end
                end
            end
            S_MOD_START: begin
                o_cmd.op = DP_MOD_START;
                n_state  = S_MOD;
            end
            S_MOD: begin
                o_cmd.op = DP_MOD_STEP;
                if (i_stat.mod_last) begin
                    n_state = (i_stat.op == OP_GET) ? S_HEAD : S_URD;
                end
            end
            S_HEAD: begin
                o_cmd.op = DP_HEAD_RD;
                n_state  = S_HCHK;
            end
            S_HCHK: begin
                o_cmd.op = DP_HCHK;
                n_state  = i_stat.cand_head ? S_LSTART : S_HCMP;
            end
            S_HCMP: begin
                o_cmd.op = DP_HCMP;
                n_state  = i_stat.tag_match ? S_HIT : S_HCHK;
            end
            S_HIT: begin
                n_hit   = 1'b1;
                n_src   = IDX_NODE;
                n_state = S_DONE;
                if (i_stat.cnt_max) begin
                    n_need = 1'b0;
                    n_st   = STS_OVER;
                end else begin
                    o_cmd.op = DP_HIT_UPD;
                    n_need   = !i_stat.cv;
                    n_st     = STS_OK;
                end
            end
            S_LSTART: begin
                o_cmd.op = DP_L_START;
                n_state  = S_LNB;
            end
            S_LNB: begin
                o_cmd.op = DP_L_NB;
                n_state  = S_LCHK;
            end
            S_LCHK: begin
                o_cmd.op = DP_L_CHK;
                if (!i_stat.cand_head) begin
                    n_state = S_LCMP;
                end else if (i_stat.k_done) begin
                    n_hit   = 1'b0;
                    n_need  = 1'b0;
                    n_st    = STS_NOFREE;
                    n_src   = IDX_ZERO;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LNB;
                end
            end
            S_LCMP: begin
                o_cmd.op = DP_L_CMP;
                n_state  = i_stat.cnt_zero ? S_GOT : S_LCHK;
            end
            S_GOT: begin
                o_cmd.op = DP_GOT;
                n_hit    = 1'b0;
                n_need   = 1'b1;
                n_st     = STS_OK;
                n_src    = IDX_NODE;
                n_state  = S_URD;
            end
            S_URD: begin
                o_cmd.op = DP_U_RD;
                n_state  = S_UWR;
            end
            S_UWR: begin
                o_cmd.op = DP_U_WR;
                n_state  = S_PRD;
            end
            S_PRD: begin
                o_cmd.op = DP_P_RD;
                n_state  = S_PWR1;
            end
            S_PWR1: begin
                o_cmd.op = DP_P_WR1;
                n_state  = S_PWR2;
            end
            S_PWR2: begin
                o_cmd.op = DP_P_WR2;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

[rtl/hlbc_datapath.sv]
module hlbc_datapath import hlbc_pkg::*; #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_req  i_req,
    output t_stat o_stat,
    output t_rsp  o_rsp
);

    localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
    localparam int NW = $clog2(NODES);
    localparam int BW = $clog2(NUM_BUFFERS);
    localparam int KW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int QW = $clog2(NUM_BUCKETS + 1);
    localparam int HW = BLK_W / 2;
    localparam int RKW = 18;
    localparam int FOLD = (1 << HW) % NUM_BUCKETS;
    localparam int RS = HW + $clog2(NUM_BUCKETS);
    localparam int RK = ((1 << RS) + NUM_BUCKETS - 1) / NUM_BUCKETS;
    localparam logic [NW-1:0] HEAD0     = NW'(NUM_BUFFERS);
    localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
    localparam logic [NW-1:0] LAST_BUF  = NW'(NUM_BUFFERS - 1);
    localparam logic [KW-1:0] LAST_BKT  = KW'(NUM_BUCKETS - 1);
    localparam logic [QW-1:0] BKTS      = QW'(NUM_BUCKETS);
    localparam logic [BLK_W-1:0] FOLD_C  = BLK_W'(FOLD);
    localparam logic [BLK_W-1:0] LO_MASK = BLK_W'((1 << HW) - 1);
    localparam logic [RKW-1:0]   RECIP   = RKW'(RK);
    localparam logic [HW-1:0]    MOD_HW  = HW'(NUM_BUCKETS);
    localparam logic [2:0]       FOLD_STEPS = 3'd3;
    localparam logic [2:0]       MOD_LAST   = 3'd4;

    t_req              r_req;
    t_rsp              r_rsp;
    logic [NW-1:0]     r_node;
    logic [NW-1:0]     r_i;
    logic [KW-1:0]     r_mod;
    logic [KW-1:0]     r_b;
    logic [QW-1:0]     r_k;
    logic [BLK_W-1:0]  r_sh;
    logic [HW-1:0]     r_q;
    logic [2:0]        r_mcnt;

    logic [TAG_W-1:0]  m_tag [NUM_BUFFERS];
    logic [CNT_W-1:0]  m_cnt [NUM_BUFFERS];
    logic              m_cv  [NUM_BUFFERS];
    logic [NW-1:0]     m_nxt [NODES];
    logic [NW-1:0]     m_prv [NODES];

    logic [TAG_W-1:0]  r_tag_rd;
    logic [CNT_W-1:0]  r_cnt_rd;
    logic              r_cv_rd;
    logic [NW-1:0]     r_nxt_rd;
    logic [NW-1:0]     r_prv_rd;

    logic              tag_we, cnt_we, cv_we, nxt_we, prv_we;
    logic [BW-1:0]     tag_wa, cnt_wa, cv_wa, buf_ra;
    logic [TAG_W-1:0]  tag_wd;
    logic [CNT_W-1:0]  cnt_wd;
    logic              cv_wd;
    logic [NW-1:0]     nxt_wa, nxt_wd, nxt_ra, prv_wa, prv_wd, prv_ra;

    logic [KW-1:0]     nb;
    logic [NW-1:0]     home_head;
    logic [BLK_W-1:0]  fold_v;
    logic [HW+RKW-1:0] recip_p;
    logic              sel_ok;

    assign nb        = (r_b == LAST_BKT) ? '0 : r_b + 1'b1;
    assign home_head = HEAD0 + NW'(r_mod);
    assign fold_v    = (r_sh >> HW) * FOLD_C + (r_sh & LO_MASK);
    assign recip_p   = (HW + RKW)'(r_sh[HW-1:0]) * (HW + RKW)'(RECIP);
    assign sel_ok    = int'(r_req.buffer_select) < NUM_BUFFERS;

    always_comb begin
        tag_we = 1'b0;
        cnt_we = 1'b0;
        cv_we  = 1'b0;
        nxt_we = 1'b0;
        prv_we = 1'b0;
        tag_wa = BW'(r_node);
        cnt_wa = BW'(r_node);
        cv_wa  = BW'(r_node);
        tag_wd = {r_req.dev, r_req.blockno};
        cnt_wd = '0;
        cv_wd  = 1'b1;
        nxt_wa = r_node;
        nxt_wd = '0;
        prv_wa = r_node;
        prv_wd = '0;
        buf_ra = BW'(r_node);
        nxt_ra = r_node;
        prv_ra = r_node;

        unique case (i_cmd.op)
            DP_INIT: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                nxt_wa = r_i;
                prv_wa = r_i;
                if (r_i < HEAD0) begin
                    nxt_wd = (r_i == '0) ? HEAD0 : r_i - 1'b1;
                    prv_wd = (r_i == LAST_BUF) ? HEAD0 : r_i + 1'b1;
                    tag_we = 1'b1;
                    cnt_we = 1'b1;
                    cv_we  = 1'b1;
                    tag_wa = BW'(r_i);
                    cnt_wa = BW'(r_i);
                    cv_wa  = BW'(r_i);
                    tag_wd = '0;
                    cv_wd  = 1'b0;
                end else if (r_i == HEAD0) begin
                    nxt_wd = LAST_BUF;
                    prv_wd = '0;
                end else begin
                    nxt_wd = r_i;
                    prv_wd = r_i;
                end
            end
            DP_HEAD_RD: nxt_ra = home_head;
            DP_HCHK: begin
                buf_ra = BW'(r_nxt_rd);
                nxt_ra = r_nxt_rd;
            end
            DP_HIT_UPD: begin
                cnt_we = 1'b1;
                cnt_wd = r_cnt_rd + 1'b1;
                cv_we  = 1'b1;
            end
            DP_L_NB: prv_ra = HEAD0 + NW'(nb);
            DP_L_CHK: begin
                buf_ra = BW'(r_prv_rd);
                prv_ra = r_prv_rd;
            end
            DP_GOT: begin
                tag_we = 1'b1;
                cnt_we = 1'b1;
                cnt_wd = CNT_W'(1);
                cv_we  = 1'b1;
            end
            DP_U_WR: begin
                nxt_we = 1'b1;
                nxt_wa = r_prv_rd;
                nxt_wd = r_nxt_rd;
                prv_we = 1'b1;
                prv_wa = r_nxt_rd;
                prv_wd = r_prv_rd;
            end
            DP_P_RD: nxt_ra = home_head;
            DP_P_WR1: begin
                nxt_we = 1'b1;
                nxt_wa = r_node;
                nxt_wd = r_nxt_rd;
                prv_we = 1'b1;
                prv_wa = r_nxt_rd;
                prv_wd = r_node;
            end
            DP_P_WR2: begin
                nxt_we = 1'b1;
                nxt_wa = home_head;
                nxt_wd = r_node;
                prv_we = 1'b1;
                prv_wa = r_node;
                prv_wd = home_head;
            end
            DP_SEL_RD: buf_ra = BW'(r_req.buffer_select);
            DP_CNT_UPD: begin
                cnt_we = 1'b1;
                cnt_wd = (r_req.op == OP_PIN) ? r_cnt_rd + 1'b1 : r_cnt_rd - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) m_tag[tag_wa] <= tag_wd;
        if (cnt_we) m_cnt[cnt_wa] <= cnt_wd;
        if (cv_we)  m_cv[cv_wa]   <= cv_wd;
        if (nxt_we) m_nxt[nxt_wa] <= nxt_wd;
        if (prv_we) m_prv[prv_wa] <= prv_wd;
        r_tag_rd <= m_tag[buf_ra];
        r_cnt_rd <= m_cnt[buf_ra];
        r_cv_rd  <= m_cv[buf_ra];
        r_nxt_rd <= m_nxt[nxt_ra];
        r_prv_rd <= m_prv[prv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_cmd.op == DP_INIT) begin
            r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: r_req <= i_req;
            DP_MOD_START: begin
                r_mod  <= '0;
                r_mcnt <= '0;
                r_sh   <= (r_req.op == OP_GET) ? r_req.blockno : r_tag_rd[BLK_W-1:0];
            end
            DP_MOD_STEP: begin
                // fold the upper half back in three times, then finish by reciprocal multiply
                if (r_mcnt < FOLD_STEPS) begin
                    r_sh <= fold_v;
                end else if (r_mcnt == FOLD_STEPS) begin
                    r_q <= HW'(recip_p >> RS);
                end else begin
                    r_mod <= KW'(r_sh[HW-1:0] - r_q * MOD_HW);
                end
                r_mcnt <= r_mcnt + 1'b1;
            end
            DP_HCHK:   r_node <= r_nxt_rd;
            DP_L_CHK:  r_node <= r_prv_rd;
            DP_SEL_RD: r_node <= NW'(r_req.buffer_select);
            DP_L_START: begin
                r_b <= r_mod;
                r_k <= '0;
            end
            DP_L_NB: begin
                r_b <= nb;
                r_k <= r_k + 1'b1;
            end
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            unique case (i_cmd.res_src)
                IDX_NODE: r_rsp.buffer_index <= SEL_W'(r_node);
                IDX_SEL:  r_rsp.buffer_index <= r_req.buffer_select;
                default:  r_rsp.buffer_index <= '0;
            endcase
            r_rsp.hit       <= i_cmd.res_hit;
            r_rsp.need_read <= i_cmd.res_need;
            r_rsp.status    <= i_cmd.res_status;
        end
    end

    always_comb begin
        o_stat.op        = r_req.op;
        o_stat.init_last = (r_i == LAST_NODE);
        o_stat.mod_last  = (r_mcnt == MOD_LAST);
        o_stat.cand_head = ((i_cmd.op == DP_L_CHK) ? r_prv_rd : r_nxt_rd) >= HEAD0;
        o_stat.tag_match = (r_tag_rd == {r_req.dev, r_req.blockno});
        o_stat.cnt_zero  = (r_cnt_rd == '0);
        o_stat.cnt_one   = (r_cnt_rd == CNT_W'(1));
        o_stat.cnt_max   = (r_cnt_rd == CNT_MAX);
        o_stat.cv        = r_cv_rd;
        o_stat.k_done    = (r_k == BKTS);
        o_stat.sel_ok    = sel_ok;
    end

    assign o_rsp = r_rsp;

endmodule

[rtl/hashed_lru_buffer_cache.sv]
// Release/pin/unpin: select check, count read and update, then the result; a release to
// zero also hashes the tag and relinks the buffer at the head of its hash bucket.
// Get: hash, home head read, one compare per home-bucket entry; a miss searches buckets
// from the one after home, tail first, for a free buffer to take, or reports none free.
// Throughput: one item at a time; the next is accepted as the result appears.
// Reset: synchronous active low; a list/tag clearing sweep then runs over all
// NUM_BUFFERS + NUM_BUCKETS list nodes, during which no item is accepted.
module hashed_lru_buffer_cache import hlbc_pkg::*; #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hlbc_stream_if.sink   i_req,
    hlbc_stream_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    t_req  req;
    t_rsp  rsp;

    assign req = i_req.payload;

    hlbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hlbc_datapath #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (req),
        .o_stat  (stat),
        .o_rsp   (rsp)
    );

    assign o_rsp.payload = rsp;

endmodule

[rtl/hlbc_checker.sv]
module hlbc_checker import hlbc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_idx,
    input logic       i_hit,
    input logic       i_need,
    input logic [1:0] i_status
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == STS_NOFREE) |-> (i_idx == '0 && !i_hit && !i_need))
        else $error("no-free result carries a buffer");

    a_need_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_need) |-> (i_status == STS_OK))
        else $error("read requested on failed get");

    a_under_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == STS_UNDER) |-> (!i_hit && !i_need))
        else $error("underflow reported on a get");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

endmodule

bind hashed_lru_buffer_cache hlbc_checker u_hlbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_idx       (o_rsp.payload.buffer_index),
    .i_hit       (o_rsp.payload.hit),
    .i_need      (o_rsp.payload.need_read),
    .i_status    (o_rsp.payload.status)
);

[tb/testbench.sv]
module testbench;
    import hlbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBUF = 32;
    localparam int NBKT = 13;
    localparam int NNODE = NBUF + NBKT;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hlbc_stream_if #(.T(t_req)) req_if ();
    hlbc_stream_if #(.T(t_rsp)) rsp_if ();

    hashed_lru_buffer_cache #(.NUM_BUFFERS(NBUF), .NUM_BUCKETS(NBKT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache shadow state
    logic [DEV_W-1:0] sh_dev [NBUF];
    logic [BLK_W-1:0] sh_blk [NBUF];
    logic [CNT_W-1:0] sh_cnt [NBUF];
    logic             sh_valid [NBUF];
    int               sh_next [NNODE];
    int               sh_prev [NNODE];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   mismatches = 0;
    int   n_hits = 0, n_misses = 0, n_nofree = 0, n_over = 0, n_under = 0;
    int   src_idle_pct = 0, snk_stall_pct = 0;
    bit   hold_off = 1'b0;
    bit   driving_done = 1'b0;
    int   idle_cycles = 0;

    function automatic void unlink_node(int n);
        int p, x;
        p = sh_prev[n];
        x = sh_next[n];
        sh_next[p] = x;
        sh_prev[x] = p;
    endfunction

    function automatic void push_front(int n, int bkt);
        int h, x;
        h = NBUF + bkt;
        x = sh_next[h];
        sh_next[n] = x;
        sh_prev[n] = h;
        sh_prev[x] = n;
        sh_next[h] = n;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < NBUF; i++) begin
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_cnt[i] = '0;
            sh_valid[i] = 1'b0;
        end
        for (int b = 0; b < NBKT; b++) begin
            sh_next[NBUF+b] = NBUF + b;
            sh_prev[NBUF+b] = NBUF + b;
        end
        for (int i = 0; i < NBUF; i++) push_front(i, 0);
    endfunction

    function automatic t_rsp cache_access(t_req r);
        t_rsp o;
        int home, h, n, b, hb, idx;
        bit found, got;
        o = '{buffer_index: r.buffer_select, hit: 1'b0, need_read: 1'b0, status: STS_OK};
        if (r.op == OP_GET) begin
            home = int'(r.blockno % NBKT);
            h = NBUF + home;
            n = sh_next[h];
            found = 1'b0;
            while (n != h) begin
                if (sh_dev[n] == r.dev && sh_blk[n] == r.blockno) begin
                    found = 1'b1;
                    break;
                end
                n = sh_next[n];
            end
            if (found) begin
                o.buffer_index = n[SEL_W-1:0];
                o.hit = 1'b1;
                n_hits++;
                if (sh_cnt[n] == CNT_MAX) begin
                    o.status = STS_OVER;
                    n_over++;
                end else begin
                    sh_cnt[n]++;
                    o.need_read = !sh_valid[n];
                    sh_valid[n] = 1'b1;
                end
            end else begin
                got = 1'b0;
                b = home;
                for (int k = 0; k < NBKT && !got; k++) begin
                    b = (b + 1) % NBKT;
                    hb = NBUF + b;
                    n = sh_prev[hb];
                    while (n != hb) begin
                        if (sh_cnt[n] == 0) begin
                            got = 1'b1;
                            break;
                        end
                        n = sh_prev[n];
                    end
                end
                if (got) begin
                    sh_dev[n] = r.dev;
                    sh_blk[n] = r.blockno;
                    sh_cnt[n] = 1;
                    unlink_node(n);
                    push_front(n, home);
                    sh_valid[n] = 1'b1;
                    o.need_read = 1'b1;
                    o.buffer_index = n[SEL_W-1:0];
                    n_misses++;
                end else begin
                    o.buffer_index = '0;
                    o.status = STS_NOFREE;
                    n_nofree++;
                end
            end
        end else if (int'(r.buffer_select) < NBUF) begin
            idx = int'(r.buffer_select);
            if (r.op == OP_PIN) begin
                if (sh_cnt[idx] == CNT_MAX) begin
                    o.status = STS_OVER;
                    n_over++;
                end else begin
                    sh_cnt[idx]++;
                end
            end else if (sh_cnt[idx] == 0) begin
                o.status = STS_UNDER;
                n_under++;
            end else begin
                sh_cnt[idx]--;
                if (r.op == OP_RELEASE && sh_cnt[idx] == 0) begin
                    unlink_node(idx);
                    push_front(idx, int'(sh_blk[idx] % NBKT));
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.payload <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) expected_rsps.push_back(cache_access(req_if.payload));
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.payload <= pending_reqs.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor and response stalls
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected transfer, index",
                                    int'(rsp_if.payload.buffer_index), -1);
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_if.payload.buffer_index !== want.buffer_index)
                        report_mismatch("buffer_index", int'(rsp_if.payload.buffer_index),
                                        int'(want.buffer_index));
                    if (rsp_if.payload.hit !== want.hit)
                        report_mismatch("hit", int'(rsp_if.payload.hit), int'(want.hit));
                    if (rsp_if.payload.need_read !== want.need_read)
                        report_mismatch("need_read", int'(rsp_if.payload.need_read),
                                        int'(want.need_read));
                    if (rsp_if.payload.status !== want.status)
                        report_mismatch("status", int'(rsp_if.payload.status),
                                        int'(want.status));
                end
            end
            rsp_if.ready <= !hold_off && ($urandom_range(99, 0) >= snk_stall_pct);
        end
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Timeout with %0d transfers outstanding", expected_rsps.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_req rand_req(bit well_formed);
        t_req r;
        r.op = t_op'($urandom_range(3, 0));
        r.dev = DEV_W'($urandom_range(3, 0));
        r.blockno = BLK_W'($urandom_range(40, 0));
        if ($urandom_range(9, 0) == 0) begin
            r.dev = DEV_W'($urandom());
            r.blockno = BLK_W'($urandom());
        end
        r.buffer_select = well_formed ? SEL_W'($urandom_range(NBUF - 1, 0))
                                      : SEL_W'($urandom());
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        src_idle_pct = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            // random ops on a small block set, mostly with valid selectors, so hits, frees and evictions recur
            pending_reqs.push_back(rand_req($urandom_range(9, 0) != 0));
        end
        wait_drained();
    endtask

    initial begin
        t_req r;
        cache_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset tag hit, extremes, every op, underflow
        r = '{op: OP_GET, dev: '0, blockno: '0, buffer_select: '0};
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);
        pending_reqs.push_back('{OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'h1F});
        pending_reqs.push_back('{OP_GET, 8'hA5, 32'h5A5A_5A5A, 5'h00});
        pending_reqs.push_back('{OP_RELEASE, 8'h00, 32'h0, 5'h1F});
        pending_reqs.push_back('{OP_UNPIN, 8'h00, 32'h0, 5'h00});
        pending_reqs.push_back('{OP_RELEASE, 8'h00, 32'h0, 5'h03});
        pending_reqs.push_back('{OP_PIN, 8'hFF, 32'hFFFF_FFFF, 5'h05});
        pending_reqs.push_back('{OP_UNPIN, 8'h00, 32'h0, 5'h05});
        pending_reqs.push_back('{OP_RELEASE, 8'h00, 32'h0, 5'h05});
        pending_reqs.push_back('{OP_GET, 8'h01, 32'd13, 5'h00});
        pending_reqs.push_back('{OP_GET, 8'h01, 32'd26, 5'h00});
        wait_drained();

        // pin buffer 7 to saturation, then probe overflow on pin
        for (int i = 0; i < 256; i++)
            pending_reqs.push_back('{OP_PIN, 8'h00, 32'h0, 5'h07});
        run_phase(0, 0, 0);
        // pin every buffer so the next miss finds no free buffer
        for (int i = 0; i < NBUF; i++)
            pending_reqs.push_back('{OP_PIN, 8'h00, 32'h0, 5'(i)});
        pending_reqs.push_back('{OP_GET, 8'h77, 32'd999, 5'h00});
        for (int i = 0; i < NBUF; i++)
            for (int j = 0; j < 3; j++)
                pending_reqs.push_back('{OP_RELEASE, 8'h00, 32'h0, 5'(i)});
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(1'b1));
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
        wait_drained();

        run_phase(70, 0, 0);
        run_phase(70, 45, 0);
        run_phase(70, 0, 45);
        run_phase(70, 20, 20);

        repeat (200) @(posedge i_clk);
        $display("Covered %0d hits, %0d misses, %0d no-free, %0d overflow, %0d underflow",
                 n_hits, n_misses, n_nofree, n_over, n_under);
        $display("under four idle and stall mixes plus a long receiver hold-off");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
